[hw/rtl/rkd_pkg.sv]
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types and register codes of the rank-k distance tile.
// ----------------------------------------------------------------------------
package rkd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE_PRIOR = 1'd1;

    localparam logic MODE_PRODUCT = 1'b0;
    localparam logic MODE_L1      = 1'b1;

    typedef struct packed {
        logic distance_mode;
        logic accumulate_prior;
    } t_cfg;

endpackage

[hw/rtl/rkd_front.sv]
// ----------------------------------------------------------------------------
// rkd_front
// Input side: takes step items and queues them, tagged with their last-step
// flag, in a two-entry queue ahead of the accumulator lanes.
// ----------------------------------------------------------------------------
module rkd_front #(
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);
    logic [DATA_W:0] r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr][DATA_W-1:0];
    assign o_last  = r_mem[r_rd_ptr][DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= {i_last, i_data};
        end
    end

endmodule

[hw/rtl/rkd_back.sv]
// ----------------------------------------------------------------------------
// rkd_back
// Accumulator lanes: one term stage (product or absolute difference) and one
// saturating add per tile position, then a drain of all sums in index order.
// ----------------------------------------------------------------------------
module rkd_back #(
    parameter  int TILE_DIM   = 4,
    parameter  int ELEM_WIDTH = 16,
    parameter  int SUM_WIDTH  = 48,
    localparam int CELLS      = TILE_DIM * TILE_DIM,
    localparam int IDX_W      = $clog2(CELLS),
    localparam int STEP_W     = 2 * TILE_DIM * ELEM_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rkd_pkg::t_cfg               i_cfg,
    input  logic                        i_step_valid,
    output logic                        o_step_ready,
    input  logic [STEP_W-1:0]           i_step_data,
    input  logic                        i_step_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [IDX_W-1:0]            o_out_index,
    output logic signed [SUM_WIDTH-1:0] o_out_sum,
    output logic                        o_out_last
);
    import rkd_pkg::*;

    localparam int TERM_W = 2 * ELEM_WIDTH;
    localparam int ADD_W  = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 1;
    localparam logic signed [ADD_W-1:0] SUM_MAX_X =
        {{(ADD_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SUM_MIN_X =
        {{(ADD_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

    logic                        r_run_open;
    logic                        r_t_vld;
    logic                        r_t_clear;
    logic                        r_t_last;
    logic signed [TERM_W-1:0]    r_term [CELLS];
    logic signed [SUM_WIDTH-1:0] r_acc  [CELLS];
    logic                        r_drain;
    logic [IDX_W-1:0]            r_cnt;
    logic                        r_out_vld;
    logic [IDX_W-1:0]            r_out_idx;
    logic signed [SUM_WIDTH-1:0] r_out_sum;
    logic                        r_out_last;
    logic                        w_take;
    logic                        w_out_load;
    logic                        w_cnt_end;

    // steps wait while a closed tile is finishing or draining
    assign o_step_ready = !r_drain && !(r_t_vld && r_t_last);
    assign w_take       = i_step_valid && o_step_ready;
    assign w_out_load   = r_drain && (!r_out_vld || i_out_ready);
    assign w_cnt_end    = (r_cnt == IDX_W'(CELLS - 1));

    for (genvar gi = 0; gi < TILE_DIM; gi++) begin : g_row
        for (genvar gj = 0; gj < TILE_DIM; gj++) begin : g_col
            localparam int K = gi * TILE_DIM + gj;
            logic signed [ELEM_WIDTH-1:0] w_a;
            logic signed [ELEM_WIDTH-1:0] w_b;
            logic signed [TERM_W-1:0]     w_prod;
            logic signed [ELEM_WIDTH:0]   w_diff;
            logic [ELEM_WIDTH:0]          w_abs;
            logic signed [TERM_W-1:0]     n_term;
            logic signed [ADD_W-1:0]      w_base;
            logic signed [ADD_W-1:0]      w_sum;
            logic signed [SUM_WIDTH-1:0]  n_acc;

            assign w_a    = i_step_data[gi*ELEM_WIDTH +: ELEM_WIDTH];
            assign w_b    = i_step_data[(TILE_DIM+gj)*ELEM_WIDTH +: ELEM_WIDTH];
            assign w_prod = w_a * w_b;
            assign w_diff = $signed({w_a[ELEM_WIDTH-1], w_a})
                          - $signed({w_b[ELEM_WIDTH-1], w_b});
            assign w_abs  = w_diff[ELEM_WIDTH] ? 
                            (ELEM_WIDTH+1)'(-w_diff) : w_diff;
            assign n_term = (i_cfg.distance_mode == MODE_L1)
                          ? $signed({{(TERM_W-ELEM_WIDTH-1){1'b0}}, w_abs})
                          : w_prod;

            assign w_base = r_t_clear ? '0 : ADD_W'(r_acc[K]);
            assign w_sum  = w_base + ADD_W'(r_term[K]);

            always_comb begin
                if (w_sum > SUM_MAX_X) begin
                    n_acc = SUM_MAX_X[SUM_WIDTH-1:0];
                end else if (w_sum < SUM_MIN_X) begin
                    n_acc = SUM_MIN_X[SUM_WIDTH-1:0];
                end else begin
                    n_acc = w_sum[SUM_WIDTH-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_take) begin
                    r_term[K] <= n_term;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc[K] <= '0;
                end else if (r_t_vld) begin
                    r_acc[K] <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
            r_t_vld    <= 1'b0;
            r_t_clear  <= 1'b0;
            r_t_last   <= 1'b0;
            r_drain    <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_t_vld <= w_take;
            if (w_take) begin
                r_t_clear  <= !r_run_open && !i_cfg.accumulate_prior;
                r_t_last   <= i_step_last;
                r_run_open <= !i_step_last;
            end
            if (r_t_vld && r_t_last) begin
                r_drain <= 1'b1;
                r_cnt   <= '0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
                r_cnt     <= r_cnt + 1'b1;
                if (w_cnt_end) begin
                    r_drain <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_idx  <= r_cnt;
            r_out_sum  <= r_acc[r_cnt];
            r_out_last <= w_cnt_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_index = r_out_idx;
    assign o_out_sum   = r_out_sum;
    assign o_out_last  = r_out_last;

endmodule

[hw/rtl/rank_k_distance_tile_4x4.sv]
// ----------------------------------------------------------------------------
// rank_k_distance_tile_4x4
// Rank-k tile update: sums a[i]*b[j] or |a[i]-b[j]| per tile position.
// ----------------------------------------------------------------------------
// Throughput: one step item per cycle within a run (parallel lanes, one
//   saturating add per lane per cycle).
// Result path: a last-step item passes the queue, term stage, add stage and
//   output register; the 16 sums follow one a cycle unless the output stalls,
//   and no step enters the lanes until the last sum is loaded.
// Reset: synchronous, active low; clears the sums, the run flag and both
//   configuration registers.
module rank_k_distance_tile_4x4 #(
    parameter  int TILE_DIM    = 4,
    parameter  int ELEM_WIDTH  = 16,
    parameter  int SUM_WIDTH   = 48,
    localparam int CELLS       = TILE_DIM * TILE_DIM,
    localparam int IDX_W       = $clog2(CELLS),
    localparam int IN_DATA_W   = 2 * TILE_DIM * ELEM_WIDTH,
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((IDX_W + SUM_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rkd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rkd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // a_elem0..a_elem(TILE_DIM-1), b_elem0..b_elem(TILE_DIM-1), zero pad
    input  logic [IN_TDATA_W-1:0]          i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,   // last_step
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // entry_index, entry_sum, zero pad
    output logic [OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                           o_m_axis_tlast    // last_entry
);
    import rkd_pkg::*;

    t_cfg                        r_cfg;
    logic                        w_step_valid;
    logic                        w_step_ready;
    logic [IN_DATA_W-1:0]        w_step_data;
    logic                        w_step_last;
    logic [IDX_W-1:0]            w_out_index;
    logic signed [SUM_WIDTH-1:0] w_out_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DISTANCE_MODE:    r_cfg.distance_mode    <= i_cfg_wdata[0];
                REG_ACCUMULATE_PRIOR: r_cfg.accumulate_prior <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rkd_front #(
        .DATA_W (IN_DATA_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata[IN_DATA_W-1:0]),
        .i_last  (i_s_axis_tlast),
        .o_valid (w_step_valid),
        .i_ready (w_step_ready),
        .o_data  (w_step_data),
        .o_last  (w_step_last)
    );

    rkd_back #(
        .TILE_DIM   (TILE_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_step_valid (w_step_valid),
        .o_step_ready (w_step_ready),
        .i_step_data  (w_step_data),
        .i_step_last  (w_step_last),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_index  (w_out_index),
        .o_out_sum    (w_out_sum),
        .o_out_last   (o_m_axis_tlast)
    );

    always_comb begin
        o_m_axis_tdata                    = '0;
        o_m_axis_tdata[IDX_W-1:0]         = w_out_index;
        o_m_axis_tdata[IDX_W +: SUM_WIDTH] = w_out_sum;
    end

endmodule

[hw/rtl/rkd_checker.sv]
// ----------------------------------------------------------------------------
// rkd_checker
// Port-level checks of the rank-k distance tile, bound to the top level.
// ----------------------------------------------------------------------------
module rkd_checker #(
    parameter  int TILE_DIM    = 4,
    parameter  int ELEM_WIDTH  = 16,
    parameter  int SUM_WIDTH   = 48,
    localparam int CELLS       = TILE_DIM * TILE_DIM,
    localparam int IDX_W       = $clog2(CELLS),
    localparam int IN_DATA_W   = 2 * TILE_DIM * ELEM_WIDTH,
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((IDX_W + SUM_WIDTH + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);
    logic [IDX_W-1:0] r_exp_idx;
    logic             w_out_acc;
    logic             w_in_acc;

    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // position the next result must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (w_out_acc) begin
            r_exp_idx <= o_m_axis_tlast ? '0 : r_exp_idx + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[IDX_W-1:0] == r_exp_idx)
        else $error("result out of index order");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tlast == (o_m_axis_tdata[IDX_W-1:0] == IDX_W'(CELLS - 1))))
        else $error("last_entry not on final tile position");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !w_out_acc)
        else $error("result valid right after reset");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !$isunknown(i_s_axis_tdata))
        else $error("unknown step data accepted");

endmodule

bind rank_k_distance_tile_4x4 rkd_checker #(
    .TILE_DIM   (TILE_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
) u_rkd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
